/* design/sbct_pkg.sv */
// Shared constants, types and codes for the swept box collision time block.
`timescale 1ns / 1ps
`default_nettype none
package sbct_pkg;
   localparam int COORD_BITS     = 16;
   localparam int STEP_FRAC_BITS = 8;
   localparam int TIME_FRAC_BITS = 16;
   localparam int STEP_W         = 24;
   localparam int DIST_W         = COORD_BITS + 1;
   localparam int AD_W           = COORD_BITS + 1;
   localparam int AS_W           = STEP_W;
   localparam int A_W            = AD_W + STEP_FRAC_BITS;
   localparam int CMP_W          = ((A_W > AS_W + 1) ? A_W : AS_W + 1) + 1;
   localparam int R_W            = AS_W + 1;
   localparam int Q_W            = TIME_FRAC_BITS + 2;
   localparam int TIME_W         = TIME_FRAC_BITS + 4;
   localparam int OUT_W          = TIME_FRAC_BITS + 1;
   localparam int LANES          = 4;
   localparam int NUM_CELLS      = Q_W;

   localparam logic signed [TIME_W-1:0] TIME_ONE = TIME_W'(1) <<< TIME_FRAC_BITS;
   localparam logic signed [TIME_W-1:0] TIME_SAT = TIME_W'(2) <<< TIME_FRAC_BITS;
   localparam logic signed [TIME_W-1:0] TIME_INF = TIME_W'(4) <<< TIME_FRAC_BITS;

   typedef enum logic [2:0] {
      SIDE_NONE   = 3'd0,
      SIDE_TOP    = 3'd1,
      SIDE_BOTTOM = 3'd2,
      SIDE_LEFT   = 3'd3,
      SIDE_RIGHT  = 3'd4
   } side_type;

   typedef enum logic [1:0] {
      LANE_X_ENTRY = 2'd0,
      LANE_X_EXIT  = 2'd1,
      LANE_Y_ENTRY = 2'd2,
      LANE_Y_EXIT  = 2'd3
   } lane_code_type;

   typedef struct packed {
      logic [R_W-1:0] rem;
      logic [Q_W-1:0] quo;
      logic [Q_W-1:0] feed;
      logic           neg;
      logic           sat;
      logic           zero;
   } lane_type;

   typedef struct packed {
      lane_type [LANES-1:0] lane;
      logic [AS_W-1:0]      abs_x;
      logic [AS_W-1:0]      abs_y;
      logic                 still_x;
      logic                 still_y;
      logic                 dxe_neg;
      logic                 dye_neg;
   } word_type;
endpackage
`default_nettype wire

/* design/sbct_prep.sv */
// Input stage: entry and exit distances, magnitudes and saturation flags.
`timescale 1ns / 1ps
`default_nettype none
module sbct_prep (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      in_valid,
   output logic                                     in_ready,
   input  wire  signed [sbct_pkg::COORD_BITS-1:0]   moving_left,
   input  wire  signed [sbct_pkg::COORD_BITS-1:0]   moving_top,
   input  wire  signed [sbct_pkg::COORD_BITS-1:0]   moving_right,
   input  wire  signed [sbct_pkg::COORD_BITS-1:0]   moving_bottom,
   input  wire  signed [sbct_pkg::COORD_BITS-1:0]   target_left,
   input  wire  signed [sbct_pkg::COORD_BITS-1:0]   target_top,
   input  wire  signed [sbct_pkg::COORD_BITS-1:0]   target_right,
   input  wire  signed [sbct_pkg::COORD_BITS-1:0]   target_bottom,
   input  wire  signed [sbct_pkg::STEP_W-1:0]       step_x,
   input  wire  signed [sbct_pkg::STEP_W-1:0]       step_y,
   output logic                                     out_valid,
   input  wire                                      out_ready,
   output sbct_pkg::word_type                       out_word
);
   import sbct_pkg::*;

   logic                       valid_ff, valid_in;
   word_type                   word_ff, word_in;
   logic signed [DIST_W-1:0]   delta [LANES];
   logic [AD_W-1:0]            mag [LANES];
   logic [A_W-1:0]             scaled [LANES];
   logic [AS_W-1:0]            abs_x, abs_y;

   function automatic logic signed [DIST_W-1:0] diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      return DIST_W'(a) - DIST_W'(b);
   endfunction

   assign in_ready = !valid_ff || out_ready;
   assign abs_x = step_x[STEP_W-1] ? AS_W'(-step_x) : AS_W'(step_x);
   assign abs_y = step_y[STEP_W-1] ? AS_W'(-step_y) : AS_W'(step_y);

   always_comb begin
      if (!step_x[STEP_W-1] && step_x != '0) begin
         delta[LANE_X_ENTRY] = diff(target_left, moving_right);
         delta[LANE_X_EXIT]  = diff(target_right, moving_left);
      end else begin
         delta[LANE_X_ENTRY] = diff(target_right, moving_left);
         delta[LANE_X_EXIT]  = diff(target_left, moving_right);
      end
      if (!step_y[STEP_W-1] && step_y != '0) begin
         delta[LANE_Y_ENTRY] = diff(target_top, moving_bottom);
         delta[LANE_Y_EXIT]  = diff(target_bottom, moving_top);
      end else begin
         delta[LANE_Y_ENTRY] = diff(target_bottom, moving_top);
         delta[LANE_Y_EXIT]  = diff(target_top, moving_bottom);
      end
      word_in = word_ff;
      word_in.abs_x   = abs_x;
      word_in.abs_y   = abs_y;
      word_in.still_x = (step_x == '0);
      word_in.still_y = (step_y == '0);
      word_in.dxe_neg = delta[LANE_X_ENTRY][DIST_W-1];
      word_in.dye_neg = delta[LANE_Y_ENTRY][DIST_W-1];
      for (int i = 0; i < LANES; i++) begin
         logic [AS_W-1:0] as_i;
         logic            s_neg;
         as_i  = (i < 2) ? abs_x : abs_y;
         s_neg = (i < 2) ? step_x[STEP_W-1] : step_y[STEP_W-1];
         mag[i] = delta[i][DIST_W-1] ? AD_W'(-delta[i]) : AD_W'(delta[i]);
         scaled[i] = A_W'(mag[i]) << STEP_FRAC_BITS;
         word_in.lane[i].neg  = delta[i][DIST_W-1] != s_neg;
         word_in.lane[i].zero = (mag[i] == '0);
         word_in.lane[i].sat  = CMP_W'(scaled[i]) > (CMP_W'(as_i) << 1);
         word_in.lane[i].rem  = R_W'(scaled[i] >> 2);
         word_in.lane[i].quo  = '0;
         word_in.lane[i].feed = {scaled[i][1:0], {TIME_FRAC_BITS{1'b0}}};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
endmodule
`default_nettype wire

/* design/sbct_cell.sv */
// Divider cell: one restoring quotient bit for each of the four lanes.
`timescale 1ns / 1ps
`default_nettype none
module sbct_cell (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   output logic               in_ready,
   input  sbct_pkg::word_type in_word,
   output logic               out_valid,
   input  wire                out_ready,
   output sbct_pkg::word_type out_word
);
   import sbct_pkg::*;

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      word_in = in_word;
      for (int i = 0; i < LANES; i++) begin
         logic [R_W-1:0] shifted;
         logic [R_W-1:0] divisor;
         divisor = (i < 2) ? R_W'(in_word.abs_x) : R_W'(in_word.abs_y);
         shifted = {in_word.lane[i].rem[R_W-2:0], in_word.lane[i].feed[Q_W-1]};
         word_in.lane[i].feed = {in_word.lane[i].feed[Q_W-2:0], 1'b0};
         if (shifted >= divisor) begin
            word_in.lane[i].rem = shifted - divisor;
            word_in.lane[i].quo = {in_word.lane[i].quo[Q_W-2:0], 1'b1};
         end else begin
            word_in.lane[i].rem = shifted;
            word_in.lane[i].quo = {in_word.lane[i].quo[Q_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
endmodule
`default_nettype wire

/* design/sbct_resolve.sv */
// Output stage: signed times, hit test, side choice and result register.
`timescale 1ns / 1ps
`default_nettype none
module sbct_resolve (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  sbct_pkg::word_type           in_word,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [sbct_pkg::OUT_W-1:0]   rsp_entry_time,
   output logic [2:0]                   rsp_side
);
   import sbct_pkg::*;

   logic                      valid_ff, valid_in;
   logic [OUT_W-1:0]          time_ff, time_in;
   side_type                  side_ff, side_in;
   logic signed [TIME_W-1:0]  t [LANES];
   logic signed [TIME_W-1:0]  entry, leave;

   assign in_ready = !valid_ff || !rsp_stall;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         logic still;
         still = (i < 2) ? in_word.still_x : in_word.still_y;
         if (still) begin
            t[i] = (i % 2 == 0) ? -TIME_INF : TIME_INF;
         end else if (in_word.lane[i].zero) begin
            t[i] = '0;
         end else if (in_word.lane[i].sat) begin
            t[i] = in_word.lane[i].neg ? -TIME_SAT : TIME_SAT;
         end else if (in_word.lane[i].neg) begin
            t[i] = -$signed(TIME_W'(in_word.lane[i].quo))
                   - TIME_W'(in_word.lane[i].rem != '0);
         end else begin
            t[i] = $signed(TIME_W'(in_word.lane[i].quo));
         end
      end
      entry = (t[LANE_X_ENTRY] > t[LANE_Y_ENTRY]) ? t[LANE_X_ENTRY] : t[LANE_Y_ENTRY];
      leave = (t[LANE_X_EXIT] < t[LANE_Y_EXIT]) ? t[LANE_X_EXIT] : t[LANE_Y_EXIT];
      if (entry > leave || (t[LANE_X_ENTRY] < 0 && t[LANE_Y_ENTRY] < 0)
          || t[LANE_X_ENTRY] > TIME_ONE || t[LANE_Y_ENTRY] > TIME_ONE) begin
         time_in = OUT_W'(TIME_ONE);
         side_in = SIDE_NONE;
      end else begin
         time_in = OUT_W'(entry);
         if (t[LANE_X_ENTRY] < t[LANE_Y_ENTRY]) begin
            side_in = in_word.dye_neg ? SIDE_TOP : SIDE_BOTTOM;
         end else begin
            side_in = in_word.dxe_neg ? SIDE_LEFT : SIDE_RIGHT;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         time_ff <= time_in;
         side_ff <= side_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_entry_time = time_ff;
   assign rsp_side       = side_ff;
endmodule
`default_nettype wire

/* design/swept_box_collision_time.sv */
// Top level of the swept box collision time block.
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | box edges, step_x, step_y
//   rsp_    | out       | rsp_valid/rsp_stall | entry_time, side
// One word enters per cycle while req_stall is low; each word passes through
// one input stage, one divider cell per quotient bit (18), one output stage.
// The four quotients of a word share the cell row and advance together.
// Reset synchronously clears every stage's valid bit.
// A stalled result holds; bubbles in the cell row still close up behind it.
`timescale 1ns / 1ps
`default_nettype none
module swept_box_collision_time (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire signed [sbct_pkg::COORD_BITS-1:0]  req_moving_left,
   input  wire signed [sbct_pkg::COORD_BITS-1:0]  req_moving_top,
   input  wire signed [sbct_pkg::COORD_BITS-1:0]  req_moving_right,
   input  wire signed [sbct_pkg::COORD_BITS-1:0]  req_moving_bottom,
   input  wire signed [sbct_pkg::COORD_BITS-1:0]  req_target_left,
   input  wire signed [sbct_pkg::COORD_BITS-1:0]  req_target_top,
   input  wire signed [sbct_pkg::COORD_BITS-1:0]  req_target_right,
   input  wire signed [sbct_pkg::COORD_BITS-1:0]  req_target_bottom,
   input  wire signed [sbct_pkg::STEP_W-1:0]      req_step_x,
   input  wire signed [sbct_pkg::STEP_W-1:0]      req_step_y,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic [sbct_pkg::OUT_W-1:0]             rsp_entry_time,
   output logic [2:0]                             rsp_side
);
   import sbct_pkg::*;

   logic     req_ready;
   logic     v [NUM_CELLS+1];
   logic     r [NUM_CELLS+1];
   word_type w [NUM_CELLS+1];

   assign req_stall = !req_ready;

   sbct_prep u_prep (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .moving_left(req_moving_left), .moving_top(req_moving_top),
      .moving_right(req_moving_right), .moving_bottom(req_moving_bottom),
      .target_left(req_target_left), .target_top(req_target_top),
      .target_right(req_target_right), .target_bottom(req_target_bottom),
      .step_x(req_step_x), .step_y(req_step_y),
      .out_valid(v[0]), .out_ready(r[0]), .out_word(w[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      sbct_cell u_cell (
         .clock(clock), .reset(reset),
         .in_valid(v[k]), .in_ready(r[k]), .in_word(w[k]),
         .out_valid(v[k+1]), .out_ready(r[k+1]), .out_word(w[k+1])
      );
   end

   sbct_resolve u_resolve (
      .clock(clock), .reset(reset),
      .in_valid(v[NUM_CELLS]), .in_ready(r[NUM_CELLS]), .in_word(w[NUM_CELLS]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_entry_time(rsp_entry_time), .rsp_side(rsp_side)
   );
endmodule
`default_nettype wire

/* design/sbct_checker.sv */
// Port checker for the swept box collision time block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sbct_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [sbct_pkg::OUT_W-1:0]    rsp_entry_time,
   input wire [2:0]                    rsp_side
);
   import sbct_pkg::*;

   localparam logic [OUT_W-1:0] ONE = OUT_W'(TIME_ONE);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_time <= ONE && rsp_side <= SIDE_RIGHT)
      else $error("result out of range");

   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_side == SIDE_NONE |-> rsp_entry_time == ONE)
      else $error("miss without full time");
endmodule

bind swept_box_collision_time sbct_checker u_sbct_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_entry_time(rsp_entry_time), .rsp_side(rsp_side)
);
`default_nettype wire

/* dv/swept_box_collision_time_tb.sv */
// Self-checking testbench for the swept box collision time block: random and directed box pairs.
`timescale 1ns / 1ps
`default_nettype none
module swept_box_collision_time_tb;
   import sbct_pkg::*;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ml, mt, mr, mb, tl, tt, tr, tb;
      logic signed [STEP_W-1:0]     sx, sy;
   } pair_type;

   typedef struct packed {
      logic [OUT_W-1:0] entry_time;
      side_type         side;
   } hit_type;

   localparam longint T_ONE = longint'(1) << TIME_FRAC_BITS;
   localparam longint T_SAT = longint'(2) << TIME_FRAC_BITS;
   localparam longint T_INF = longint'(4) << TIME_FRAC_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pair_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_W-1:0] rsp_entry_time;
   logic [2:0] rsp_side;

   pair_type pending_pairs[$];
   hit_type  expected_hits[$];
   int errors = 0;
   int hits_seen = 0;
   int misses_seen = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   bit stim_done = 1'b0;

   swept_box_collision_time uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_moving_left(req_word.ml), .req_moving_top(req_word.mt),
      .req_moving_right(req_word.mr), .req_moving_bottom(req_word.mb),
      .req_target_left(req_word.tl), .req_target_top(req_word.tt),
      .req_target_right(req_word.tr), .req_target_bottom(req_word.tb),
      .req_step_x(req_word.sx), .req_step_y(req_word.sy),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_entry_time(rsp_entry_time), .rsp_side(rsp_side)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint time_quotient(longint d, longint s);
      bit neg;
      longint ad, as_, num, q;
      neg = (d < 0) != (s < 0);
      ad = (d < 0) ? -d : d;
      as_ = (s < 0) ? -s : s;
      if (ad == 0) return 0;
      if ((ad << STEP_FRAC_BITS) > 2 * as_) return neg ? -T_SAT : T_SAT;
      num = ad << (STEP_FRAC_BITS + TIME_FRAC_BITS);
      q = num / as_;
      if (!neg) return q;
      return -q - ((num % as_) != 0 ? 1 : 0);
   endfunction

   function automatic void axis_span(input longint lo, hi, tlo, thi, stp,
                                     output longint d_in, t_in, t_out);
      longint d_out;
      if (stp > 0) begin
         d_in = tlo - hi;
         d_out = thi - lo;
      end else begin
         d_in = thi - lo;
         d_out = tlo - hi;
      end
      if (stp == 0) begin
         t_in = -T_INF;
         t_out = T_INF;
      end else begin
         t_in = time_quotient(d_in, stp);
         t_out = time_quotient(d_out, stp);
      end
   endfunction

   function automatic hit_type predict_contact(pair_type p);
      longint dxe, dye, txe, txx, tye, tyx, first_in, first_out;
      hit_type h;
      axis_span(p.ml, p.mr, p.tl, p.tr, p.sx, dxe, txe, txx);
      axis_span(p.mt, p.mb, p.tt, p.tb, p.sy, dye, tye, tyx);
      first_in = (txe > tye) ? txe : tye;
      first_out = (txx < tyx) ? txx : tyx;
      if (first_in > first_out || (txe < 0 && tye < 0) || txe > T_ONE || tye > T_ONE) begin
         h.entry_time = OUT_W'(T_ONE);
         h.side = SIDE_NONE;
      end else begin
         h.entry_time = OUT_W'(first_in);
         if (txe < tye) h.side = (dye < 0) ? SIDE_TOP : SIDE_BOTTOM;
         else h.side = (dxe < 0) ? SIDE_LEFT : SIDE_RIGHT;
      end
      return h;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic pair_type raw_pair();
      pair_type p;
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
      return p;
   endfunction

   // Build a pair of nearby boxes with random spacing, sizes and steps.
   function automatic pair_type course_pair();
      pair_type p;
      int w, hgt, tw, th, gx, gy, sc;
      sc = ($urandom_range(0, 9) == 0) ? 8000 : 60;
      w = $urandom_range(0, sc);
      hgt = $urandom_range(0, sc);
      tw = $urandom_range(0, sc);
      th = $urandom_range(0, sc);
      p.ml = COORD_BITS'($signed($urandom_range(0, 2000)) - 1000);
      p.mt = COORD_BITS'($signed($urandom_range(0, 2000)) - 1000);
      p.mr = p.ml + COORD_BITS'(w);
      p.mb = p.mt + COORD_BITS'(hgt);
      gx = $signed($urandom_range(0, 2 * sc)) - sc / 2;
      gy = $signed($urandom_range(0, 2 * sc)) - sc / 2;
      if ($urandom_range(0, 1)) begin
         p.tl = p.mr + COORD_BITS'(gx);
         p.tr = p.tl + COORD_BITS'(tw);
      end else begin
         p.tr = p.ml - COORD_BITS'(gx);
         p.tl = p.tr - COORD_BITS'(tw);
      end
      if ($urandom_range(0, 1)) begin
         p.tt = p.mb + COORD_BITS'(gy);
         p.tb = p.tt + COORD_BITS'(th);
      end else begin
         p.tb = p.mt - COORD_BITS'(gy);
         p.tt = p.tb - COORD_BITS'(th);
      end
      p.sx = STEP_W'($signed($urandom_range(0, 2 * 256 * sc)) - 256 * sc);
      p.sy = STEP_W'($signed($urandom_range(0, 2 * 256 * sc)) - 256 * sc);
      if ($urandom_range(0, 9) == 0) p.sx = '0;
      if ($urandom_range(0, 9) == 0) p.sy = '0;
      return p;
   endfunction

   function automatic pair_type box_pair(int ml, mt, mr, mb, tl, tt, tr, tb, sx, sy);
      pair_type p;
      p.ml = COORD_BITS'(ml); p.mt = COORD_BITS'(mt);
      p.mr = COORD_BITS'(mr); p.mb = COORD_BITS'(mb);
      p.tl = COORD_BITS'(tl); p.tt = COORD_BITS'(tt);
      p.tr = COORD_BITS'(tr); p.tb = COORD_BITS'(tb);
      p.sx = STEP_W'(sx); p.sy = STEP_W'(sy);
      return p;
   endfunction

   initial begin
      pair_type p;
      // head-on hits on each side, both still axes, one still axis
      pending_pairs.push_back(box_pair(0, 0, 10, 10, 20, 0, 30, 10, 20 << 8, 0));
      pending_pairs.push_back(box_pair(40, 0, 50, 10, 20, 0, 30, 10, -(20 << 8), 0));
      pending_pairs.push_back(box_pair(0, 0, 10, 10, 0, 20, 10, 30, 0, 20 << 8));
      pending_pairs.push_back(box_pair(0, 40, 10, 50, 0, 20, 10, 30, 0, -(20 << 8)));
      pending_pairs.push_back(box_pair(0, 0, 10, 10, 20, 20, 30, 30, 0, 0));
      pending_pairs.push_back(box_pair(0, 0, 10, 10, 5, 5, 15, 15, 0, 0));
      // touching, far miss, overlap, saturation, negative rounding
      pending_pairs.push_back(box_pair(0, 0, 10, 10, 10, 0, 20, 10, 1, 0));
      pending_pairs.push_back(box_pair(0, 0, 10, 10, 500, 0, 510, 10, 1 << 8, 0));
      pending_pairs.push_back(box_pair(0, 0, 10, 10, 5, 5, 15, 15, 3 << 8, 7 << 8));
      pending_pairs.push_back(box_pair(0, 0, 10, 10, 13, 11, 20, 20, 7 << 8, 3 << 8));
      pending_pairs.push_back(box_pair(0, 0, 10, 10, 13, 11, 20, 20, 3 << 8, 7 << 8));
      pending_pairs.push_back(box_pair(0, 0, 10, 10, 13, 11, 20, 20, 3 << 8, 3 << 8));
      pending_pairs.push_back(box_pair(-7, -3, 2, 4, -20, -30, -10, -5, -1001, -777));
      pending_pairs.push_back(box_pair(-32768, -32768, 32767, 32767,
                                       32767, -32768, -32768, 32767, 8388607, -8388608));
      pending_pairs.push_back(box_pair(32767, 32767, -32768, -32768,
                                       -32768, 32767, 32767, -32768, -8388608, 8388607));
      pending_pairs.push_back(box_pair(-32768, 0, -32768, 0, 32767, 0, 32767, 0, 1, -1));
      pending_pairs.push_back(box_pair(0, 0, 0, 0, 1, 1, 1, 1, 8388607, 8388607));
      pending_pairs.push_back(box_pair(0, 0, 0, 0, 0, 0, 0, 0, -1, -1));
      // inverted boxes
      pending_pairs.push_back(box_pair(10, 10, 0, 0, 30, 30, 20, 20, 5000, 5000));
      pending_pairs.push_back('1);
      pending_pairs.push_back('0);
      repeat (1530) begin
         p = ($urandom_range(0, 9) < 8) ? course_pair() : raw_pair();
         pending_pairs.push_back(p);
      end
      stim_done = 1'b1;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) req_gap <= pick_gap();
         if ((req_valid ? req_gap == 0 : req_gap == 0) && pending_pairs.size() > 0 &&
             !(req_valid && req_gap != 0)) begin
            req_word <= pending_pairs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            if (!req_valid && req_gap > 0) req_gap <= req_gap - 1;
         end
      end
   end

   // Record the expectation for each word taken by the block.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_hits.push_back(predict_contact(req_word));
   end

   always @(posedge clock) begin
      hit_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               $error("unexpected result word");
               errors++;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_entry_time !== want.entry_time) begin
                  $error("entry_time expected %0d actual %0d", want.entry_time, rsp_entry_time);
                  errors++;
               end
               if (rsp_side !== want.side) begin
                  $error("side expected %0d actual %0d", want.side, rsp_side);
                  errors++;
               end
               if (want.side == SIDE_NONE) misses_seen++;
               else hits_seen++;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_gap <= pick_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      @(posedge clock);
      while (pending_pairs.size() > 0 || req_valid || expected_hits.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Checked %0d hits and %0d misses over directed and random box pairs.",
               hits_seen, misses_seen);
      if (errors == 0 && expected_hits.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
design/sbct_pkg.sv
design/sbct_prep.sv
design/sbct_cell.sv
design/sbct_resolve.sv
design/swept_box_collision_time.sv
design/sbct_checker.sv
dv/swept_box_collision_time_tb.sv
